// ===== rtl/core/bst5_pkg.sv =====
// Shared constants, types and helpers of the byte statistics block.
`timescale 1ns / 1ps
`default_nettype none

package bst5_pkg;

  localparam int BINS     = 256;
  localparam int ADDR_W   = $clog2(BINS);
  localparam int TOP_K    = 5;
  localparam int RANK_W   = 3;
  localparam int COUNT_W  = 32;
  localparam int DIST_W   = 9;
  localparam int LEN_W    = 8;
  localparam int MAX_WORD = 255;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [LEN_W-1:0]   len_t;

  localparam logic OP_TEXT   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LO_A  = 8'd97;
  localparam logic [7:0] CH_LO_Z  = 8'd122;

  localparam count_t COUNT_MAX = '1;
  localparam rank_t  LAST_RANK = rank_t'(TOP_K - 1);
  localparam addr_t  LAST_BIN  = addr_t'(BINS - 1);
  localparam len_t   WORD_LIMIT = len_t'(MAX_WORD);

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bst5_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module bst5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/byte_stats_top_five_core.sv =====
// Byte histogram with line, word and byte totals and a ranked top-five report.
//
// The input channel carries one word per item: opcode_i selects a text byte
// (byte_value_i) or a finish request. Text bytes are taken one per cycle while
// idle; unless word_overflow_o is set, each is counted in a 256-bin histogram
// held in a RAM with a registered read, updated by read, increment and write
// back, with forwarding when the same bin is hit in consecutive cycles. Totals
// and the word tokenizer sit in registers.
// A finish word first clears the top list in a drain state, then walks
// the RAM once, one bin per cycle, keeping a sorted list of the five largest
// bins. The report follows as five output words, rank 0 first, the last one
// flagged by last_of_report_o. Input is not taken from the finish until the
// fifth result is taken.
// A stalled receiver holds the current result steady. After the fifth result
// all counts return to zero. Reset clears the bin valid bits and all totals,
// so the histogram reads as zero at once and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module byte_stats_top_five_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             opcode_i,
  input  wire logic [7:0]       byte_value_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bst5_pkg::rank_t       rank_o,
  output logic [7:0]            symbol_o,
  output bst5_pkg::count_t      symbol_count_o,
  output bst5_pkg::count_t      line_total_o,
  output bst5_pkg::count_t      word_total_o,
  output bst5_pkg::count_t      byte_total_o,
  output bst5_pkg::dist_t       distinct_total_o,
  output logic                  word_overflow_o,
  output logic                  last_of_report_o
);

  import bst5_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  logic   in_acc, text_take, fin_take, out_acc, report_done;
  logic   is_digit, is_letter, end_w, add_c;
  len_t   len_base, len_inc;

  count_t lines_q, lines_d, words_q, words_d, bytes_q, bytes_d;
  dist_t  dist_q, dist_d;
  len_t   len_q, len_d;
  logic   saw_digit_q, saw_digit_d, saw_letter_q, saw_letter_d;
  logic   ovf_q, ovf_d;

  logic [BINS-1:0] bin_vld_q;
  logic   wr_v_q;
  addr_t  wr_addr_q;
  logic   fwd_v_q;
  addr_t  fwd_addr_q;
  count_t fwd_data_q;
  count_t old_cnt, new_cnt;

  addr_t  ram_raddr;
  count_t ram_rdata;

  addr_t  scan_addr_q;
  logic   rd_v_q;
  addr_t  rd_addr_q;
  count_t scan_cnt;
  logic   scan_hit;

  rank_t  rank_q;
  count_t top_cnt_q [TOP_K];
  logic [7:0] top_sym_q [TOP_K];
  logic [TOP_K-1:0] top_vld_q;
  logic [TOP_K-1:0] gt;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign text_take   = in_acc && (opcode_i == OP_TEXT) && !ovf_q;
  assign fin_take    = in_acc && (opcode_i == OP_FINISH);
  assign out_acc     = out_valid_o && out_ready_i;
  assign report_done = out_acc && (rank_q == LAST_RANK);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (fin_take) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_SCAN;
      ST_SCAN:  if (rd_v_q && (rd_addr_q == LAST_BIN)) state_d = ST_EMIT;
      ST_EMIT:  if (report_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Tokenizer and totals.
  assign is_digit  = (byte_value_i >= CH_0) && (byte_value_i <= CH_9);
  assign is_letter = ((byte_value_i >= CH_UP_A) && (byte_value_i <= CH_UP_Z)) ||
                     ((byte_value_i >= CH_LO_A) && (byte_value_i <= CH_LO_Z));
  assign end_w     = !is_digit && (!is_letter || (saw_digit_q && !saw_letter_q));
  assign add_c     = is_digit || is_letter;
  assign len_base  = end_w ? '0 : len_q;
  assign len_inc   = len_base + len_t'(1);

  always_comb begin
    lines_d      = lines_q;
    words_d      = words_q;
    bytes_d      = bytes_q;
    len_d        = len_q;
    saw_digit_d  = saw_digit_q;
    saw_letter_d = saw_letter_q;
    ovf_d        = ovf_q;
    if (text_take) begin
      bytes_d = sat_inc(bytes_q);
      if (byte_value_i == CH_NL) begin
        lines_d = sat_inc(lines_q);
      end
      if (end_w && (len_q != '0)) begin
        words_d = sat_inc(words_q);
      end
      len_d = add_c ? len_inc : '0;
      if (add_c && (len_inc >= WORD_LIMIT)) begin
        ovf_d = 1'b1;
      end
      saw_digit_d  = is_digit ? 1'b1 : (is_letter ? (saw_digit_q && !end_w) : 1'b0);
      saw_letter_d = is_letter ? 1'b1 : (is_digit ? saw_letter_q : 1'b0);
    end
    if (fin_take && !ovf_q && (len_q != '0)) begin
      words_d = sat_inc(words_q);
      len_d   = '0;
    end
    if (report_done) begin
      lines_d      = '0;
      words_d      = '0;
      bytes_d      = '0;
      len_d        = '0;
      saw_digit_d  = 1'b0;
      saw_letter_d = 1'b0;
      ovf_d        = 1'b0;
    end
  end

  // Histogram update: the second stage sees the read data of the first.
  assign ram_raddr = (state_q == ST_IDLE) ? byte_value_i : scan_addr_q;

  always_comb begin
    if (fwd_v_q && (fwd_addr_q == wr_addr_q)) begin
      old_cnt = fwd_data_q;
    end else if (bin_vld_q[wr_addr_q]) begin
      old_cnt = ram_rdata;
    end else begin
      old_cnt = '0;
    end
    new_cnt = sat_inc(old_cnt);
    dist_d  = dist_q;
    if (wr_v_q && (old_cnt == '0)) begin
      dist_d = dist_q + dist_t'(1);
    end
    if (report_done) begin
      dist_d = '0;
    end
  end

  bst5_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(BINS)
  ) u_bin_ram (
    .clk_i  (clk_i),
    .we_i   (wr_v_q),
    .waddr_i(wr_addr_q),
    .wdata_i(new_cnt),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sorted insertion of each scanned bin into the top list.
  assign scan_cnt = bin_vld_q[rd_addr_q] ? ram_rdata : '0;
  assign scan_hit = rd_v_q && (state_q == ST_SCAN);

  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      gt[k] = !top_vld_q[k] || (scan_cnt > top_cnt_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lines_q      <= '0;
      words_q      <= '0;
      bytes_q      <= '0;
      dist_q       <= '0;
      len_q        <= '0;
      saw_digit_q  <= 1'b0;
      saw_letter_q <= 1'b0;
      ovf_q        <= 1'b0;
      bin_vld_q    <= '0;
      wr_v_q       <= 1'b0;
      fwd_v_q      <= 1'b0;
      rd_v_q       <= 1'b0;
      top_vld_q    <= '0;
      rank_q       <= '0;
      scan_addr_q  <= '0;
    end else begin
      state_q      <= state_d;
      lines_q      <= lines_d;
      words_q      <= words_d;
      bytes_q      <= bytes_d;
      dist_q       <= dist_d;
      len_q        <= len_d;
      saw_digit_q  <= saw_digit_d;
      saw_letter_q <= saw_letter_d;
      ovf_q        <= ovf_d;
      wr_v_q       <= text_take;
      fwd_v_q      <= wr_v_q;
      rd_v_q       <= (state_q == ST_SCAN);
      if (wr_v_q) begin
        bin_vld_q[wr_addr_q] <= 1'b1;
      end
      if (state_q == ST_DRAIN) begin
        scan_addr_q <= '0;
        top_vld_q   <= '0;
        rank_q      <= '0;
      end
      if (state_q == ST_SCAN) begin
        scan_addr_q <= scan_addr_q + addr_t'(1);
      end
      if (scan_hit) begin
        if (gt[0]) begin
          top_vld_q[0] <= 1'b1;
        end
        for (int k = 1; k < TOP_K; k++) begin
          if (gt[k]) begin
            top_vld_q[k] <= gt[k-1] ? top_vld_q[k-1] : 1'b1;
          end
        end
      end
      if (out_acc) begin
        rank_q    <= rank_q + rank_t'(1);
        top_vld_q <= top_vld_q >> 1;
      end
      if (report_done) begin
        bin_vld_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_take) begin
      wr_addr_q <= byte_value_i;
    end
    fwd_addr_q <= wr_addr_q;
    fwd_data_q <= new_cnt;
    rd_addr_q  <= scan_addr_q;
    if (scan_hit) begin
      if (gt[0]) begin
        top_cnt_q[0] <= scan_cnt;
        top_sym_q[0] <= rd_addr_q;
      end
      for (int k = 1; k < TOP_K; k++) begin
        if (gt[k]) begin
          if (!gt[k-1]) begin
            top_cnt_q[k] <= scan_cnt;
            top_sym_q[k] <= rd_addr_q;
          end else begin
            top_cnt_q[k] <= top_cnt_q[k-1];
            top_sym_q[k] <= top_sym_q[k-1];
          end
        end
      end
    end
    if (out_acc) begin
      for (int k = 0; k < TOP_K - 1; k++) begin
        top_cnt_q[k] <= top_cnt_q[k+1];
        top_sym_q[k] <= top_sym_q[k+1];
      end
    end
  end

  assign rank_o           = rank_q;
  assign symbol_o         = top_sym_q[0];
  assign symbol_count_o   = top_cnt_q[0];
  assign line_total_o     = lines_q;
  assign word_total_o     = words_q;
  assign byte_total_o     = bytes_q;
  assign distinct_total_o = dist_q;
  assign word_overflow_o  = ovf_q;
  assign last_of_report_o = (rank_q == LAST_RANK);

endmodule

`default_nettype wire

// ===== rtl/core/bst5_checker.sv =====
// Port-level checks of the byte statistics block and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bst5_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             opcode_i,
  input wire logic [7:0]       byte_value_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire bst5_pkg::rank_t  rank_o,
  input wire logic [7:0]       symbol_o,
  input wire bst5_pkg::count_t symbol_count_o,
  input wire bst5_pkg::count_t line_total_o,
  input wire bst5_pkg::count_t word_total_o,
  input wire bst5_pkg::count_t byte_total_o,
  input wire bst5_pkg::dist_t  distinct_total_o,
  input wire logic             word_overflow_o,
  input wire logic             last_of_report_o
);

  import bst5_pkg::*;

  a_no_input_during_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("Input is ready while a report is pending.");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(symbol_o) && $stable(symbol_count_o) && $stable(rank_o)))
    else $error("A stalled result changed.");

  a_rank_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_report_o) |=>
      (out_valid_o && (rank_o == $past(rank_o) + rank_t'(1))))
    else $error("Ranks of a report are not consecutive.");

  a_report_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_report_o) |=>
      (!out_valid_o && in_ready_o && (byte_total_o == '0) && (distinct_total_o == '0)))
    else $error("The block did not return to an empty idle state after a report.");

  a_counts_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_report_o) |=>
      (symbol_count_o <= $past(symbol_count_o)))
    else $error("Report counts are not in descending order.");

endmodule

bind byte_stats_top_five_core bst5_checker u_bst5_checker (.*);

`default_nettype wire
